>>> sv/vvu_pkg.sv
// Shared types, widths and constants of the vortex velocity update block.
package vvu_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned TAG_W   = 16;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned DT_W    = 16;
  localparam int unsigned AXIS_W  = 18;
  localparam int unsigned GAIN_W  = 20;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Internal value ranges (independent of the fraction width since |h| <= 1.0)
  localparam int unsigned DW  = POS_W + 1;   // pos - centre
  localparam int unsigned PW  = 35;          // axial projection
  localparam int unsigned RW  = 36;          // radial vector
  localparam int unsigned CW  = 36;          // tangential direction
  localparam int unsigned WW  = 27;          // angular speed in rad/s and times dt
  localparam int unsigned GDW = GAIN_W;      // gain times dt

  localparam int unsigned S_W    = 2 * AXIS_W;  // squared axis length
  localparam int unsigned ROOT_W = AXIS_W;      // axis length

  // round(pi / 180 * 2^32)
  localparam logic [27:0] DEG2RAD_Q32 = 28'd74961321;

  localparam logic signed [AXIS_W-1:0] AXIS_X_RST = '0;
  localparam logic signed [AXIS_W-1:0] AXIS_Y_RST = AXIS_W'(65536);
  localparam logic signed [AXIS_W-1:0] AXIS_Z_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X      = 3'd0,
    REG_CENTER_Y      = 3'd1,
    REG_CENTER_Z      = 3'd2,
    REG_AXIS_X        = 3'd3,
    REG_AXIS_Y        = 3'd4,
    REG_AXIS_Z        = 3'd5,
    REG_ANGULAR_SPEED = 3'd6,
    REG_ATTRACT_GAIN  = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    NRM_IDLE = 2'd0,
    NRM_SQRT = 2'd1,
    NRM_DIV  = 2'd2
  } nrm_state_e;

  typedef struct packed {
    logic busy;
    logic nonzero;
  } nrm_stat_t;

endpackage

>>> sv/vvu_norm.sv
// Axis normalizer: bit-serial integer square root and one shared restoring divider.
module vvu_norm import vvu_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [AXIS_W-1:0]      axis_x_i,
  input  logic signed [AXIS_W-1:0]      axis_y_i,
  input  logic signed [AXIS_W-1:0]      axis_z_i,
  output nrm_stat_t                     stat_o,
  output logic signed [FRAC_BITS+1:0]   h_x_o,
  output logic signed [FRAC_BITS+1:0]   h_y_o,
  output logic signed [FRAC_BITS+1:0]   h_z_o
);

  localparam int unsigned HW    = FRAC_BITS + 2;
  localparam int unsigned NW    = AXIS_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NW + 1);

  nrm_state_e state_q, state_d;

  logic [S_W-1:0]      n_q, res_q, bit_q;
  logic [AXIS_W-1:0]   mag_q [3];
  logic                neg_q [3];
  logic [1:0]          comp_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [ROOT_W:0]     rem_q;
  logic [NW-1:0]       quo_q, dvd_q;
  logic signed [HW-1:0] h_q [3];
  logic                nonzero_q;

  logic [AXIS_W-1:0]   mag_in [3];
  logic [S_W-1:0]      s_w;
  logic [S_W:0]        trial_w;
  logic                sq_take;
  logic [ROOT_W+1:0]   div_t;
  logic [ROOT_W+1:0]   root_w;
  logic                div_take;
  logic [NW-1:0]       quo_next;
  logic [HW-1:0]       q_mag;
  logic                last_bit;

  always_comb begin
    mag_in[0] = axis_x_i[AXIS_W-1] ? AXIS_W'(-axis_x_i) : axis_x_i;
    mag_in[1] = axis_y_i[AXIS_W-1] ? AXIS_W'(-axis_y_i) : axis_y_i;
    mag_in[2] = axis_z_i[AXIS_W-1] ? AXIS_W'(-axis_z_i) : axis_z_i;
    s_w = S_W'(mag_in[0] * mag_in[0]) + S_W'(mag_in[1] * mag_in[1])
        + S_W'(mag_in[2] * mag_in[2]);
  end

  // Square root step: one result bit per cycle
  always_comb begin
    trial_w = {1'b0, res_q} + {1'b0, bit_q};
    sq_take = ({1'b0, n_q} >= trial_w);
  end

  // Divider step: one quotient bit per cycle
  always_comb begin
    div_t    = {rem_q, dvd_q[NW-1]};
    root_w   = (ROOT_W+2)'(res_q[ROOT_W-1:0]);
    div_take = (div_t >= root_w);
    quo_next = {quo_q[NW-2:0], div_take};
    q_mag    = quo_next[HW-1:0];
    last_bit = (cnt_q == CNT_W'(NW - 1));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      NRM_IDLE: begin
        if (start_i && (s_w != '0)) state_d = NRM_SQRT;
      end
      NRM_SQRT: begin
        if (bit_q == S_W'(1)) state_d = NRM_DIV;
      end
      NRM_DIV: begin
        if (last_bit && (comp_q == 2'd2)) state_d = NRM_IDLE;
      end
      default: state_d = NRM_IDLE;
    endcase
  end

  always_comb begin
    stat_o.busy    = (state_q != NRM_IDLE);
    stat_o.nonzero = nonzero_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= NRM_IDLE;
      nonzero_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == NRM_IDLE) && start_i) nonzero_q <= (s_w != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      NRM_IDLE: begin
        if (start_i) begin
          n_q    <= s_w;
          res_q  <= '0;
          bit_q  <= S_W'(1) << (S_W - 2);
          comp_q <= 2'd0;
          mag_q[0] <= mag_in[0];
          mag_q[1] <= mag_in[1];
          mag_q[2] <= mag_in[2];
          neg_q[0] <= axis_x_i[AXIS_W-1];
          neg_q[1] <= axis_y_i[AXIS_W-1];
          neg_q[2] <= axis_z_i[AXIS_W-1];
        end
      end
      NRM_SQRT: begin
        if (sq_take) begin
          n_q   <= n_q - trial_w[S_W-1:0];
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        cnt_q <= '0;
        rem_q <= '0;
        quo_q <= '0;
        dvd_q <= NW'(mag_q[0]) << FRAC_BITS;
      end
      NRM_DIV: begin
        if (last_bit) begin
          h_q[comp_q] <= neg_q[comp_q] ? HW'(-$signed(q_mag)) : $signed(q_mag);
          comp_q <= comp_q + 2'd1;
          cnt_q  <= '0;
          rem_q  <= '0;
          quo_q  <= '0;
          if (comp_q != 2'd2) dvd_q <= NW'(mag_q[comp_q + 2'd1]) << FRAC_BITS;
        end else begin
          rem_q <= div_take ? (ROOT_W+1)'(div_t - root_w) : div_t[ROOT_W:0];
          quo_q <= quo_next;
          dvd_q <= dvd_q << 1;
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      default: begin
        cnt_q <= '0;
      end
    endcase
  end

  assign h_x_o = h_q[0];
  assign h_y_o = h_q[1];
  assign h_z_o = h_q[2];

endmodule

>>> sv/vortex_velocity_update.sv
// Vortex velocity update: nine-stage particle pipeline with configuration registers.
// Throughput: one particle per cycle while busy is low; the receiver cannot stall the pipeline.
// Reset, and each axis register write, start the axis normalizer (isqrt, then a shared
// bit-serial divider for three components): busy stays high while it runs, and no
// particle or register beat is taken then.
module vortex_velocity_update import vvu_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // particle channel
  input  logic                          start,
  output logic                          busy,
  input  logic [TAG_W-1:0]              particle_tag_i,
  input  logic signed [POS_W-1:0]       pos_x_i,
  input  logic signed [POS_W-1:0]       pos_y_i,
  input  logic signed [POS_W-1:0]       pos_z_i,
  input  logic signed [POS_W-1:0]       vel_x_i,
  input  logic signed [POS_W-1:0]       vel_y_i,
  input  logic signed [POS_W-1:0]       vel_z_i,
  input  logic [DT_W-1:0]               time_step_i,
  // result channel
  output logic                          valid_o,
  output logic [TAG_W-1:0]              out_tag_o,
  output logic signed [POS_W-1:0]       new_vel_x_o,
  output logic signed [POS_W-1:0]       new_vel_y_o,
  output logic signed [POS_W-1:0]       new_vel_z_o,
  output logic                          applied_o,
  // register write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int unsigned HW    = FRAC_BITS + 2;     // unit axis component
  localparam int unsigned DHW   = DW + HW;           // d_i * h_i
  localparam int unsigned DSW   = DHW + 2;           // dot product sum
  localparam int unsigned HPW   = HW + PW;           // h_i * p
  localparam int unsigned HRW   = HW + RW;           // h_i * r_j
  localparam int unsigned CWW   = CW + WW;           // c_i * wdt
  localparam int unsigned RGW   = RW + GDW + 1;      // r_i * gdt
  localparam int unsigned WPW   = POS_W + 28;        // speed * deg2rad
  localparam int unsigned WDW   = WW + DT_W + 1;     // w * dt
  localparam int unsigned SUM_W = CWW + 1;
  localparam int unsigned NS    = 8;                 // stages ahead of the output register

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

  // ---------------------------------------------------------------------------
  // Configuration registers. Axis writes re-run the normalizer; beats are held
  // off while it runs so the unit vector never changes under a write.
  // ---------------------------------------------------------------------------
  logic signed [POS_W-1:0]  center_q [3];
  logic signed [AXIS_W-1:0] axis_x_q, axis_y_q, axis_z_q;
  logic signed [POS_W-1:0]  speed_q;
  logic [GAIN_W-1:0]        gain_q;
  logic                     norm_req_q, norm_req_d;
  logic                     cfg_fire;
  logic                     in_fire;
  nrm_stat_t                nrm_stat;
  logic signed [HW-1:0]     h_w [3];

  assign busy        = nrm_stat.busy | norm_req_q;
  assign cfg_ready_o = ~busy;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign in_fire     = start & ~busy;

  always_comb begin
    norm_req_d = 1'b0;
    if (cfg_fire) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_AXIS_X, REG_AXIS_Y, REG_AXIS_Z: norm_req_d = 1'b1;
        default: norm_req_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q[0] <= '0;
      center_q[1] <= '0;
      center_q[2] <= '0;
      axis_x_q    <= AXIS_X_RST;
      axis_y_q    <= AXIS_Y_RST;
      axis_z_q    <= AXIS_Z_RST;
      speed_q     <= '0;
      gain_q      <= '0;
      norm_req_q  <= 1'b1;   // normalize the reset axis
    end else begin
      norm_req_q <= norm_req_d;
      if (cfg_fire) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_CENTER_X:      center_q[0] <= cfg_data_i;
          REG_CENTER_Y:      center_q[1] <= cfg_data_i;
          REG_CENTER_Z:      center_q[2] <= cfg_data_i;
          REG_AXIS_X:        axis_x_q    <= cfg_data_i[AXIS_W-1:0];
          REG_AXIS_Y:        axis_y_q    <= cfg_data_i[AXIS_W-1:0];
          REG_AXIS_Z:        axis_z_q    <= cfg_data_i[AXIS_W-1:0];
          REG_ANGULAR_SPEED: speed_q     <= cfg_data_i;
          REG_ATTRACT_GAIN:  gain_q      <= cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  vvu_norm #(
    .FRAC_BITS(FRAC_BITS)
  ) u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (norm_req_q),
    .axis_x_i (axis_x_q),
    .axis_y_i (axis_y_q),
    .axis_z_i (axis_z_q),
    .stat_o   (nrm_stat),
    .h_x_o    (h_w[0]),
    .h_y_o    (h_w[1]),
    .h_z_o    (h_w[2])
  );

  // ---------------------------------------------------------------------------
  // Side lines: tag, velocity and the axis flag ride along with the valid bits.
  // ---------------------------------------------------------------------------
  logic [NS-1:0]           vld_q;
  logic [TAG_W-1:0]        tag_q [NS];
  logic signed [POS_W-1:0] vel_q [NS][3];
  logic                    aok_q [NS];
  logic signed [POS_W-1:0] pos_w [3];
  logic signed [POS_W-1:0] vel_w [3];

  assign pos_w[0] = pos_x_i;
  assign pos_w[1] = pos_y_i;
  assign pos_w[2] = pos_z_i;
  assign vel_w[0] = vel_x_i;
  assign vel_w[1] = vel_y_i;
  assign vel_w[2] = vel_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else begin
      vld_q   <= {vld_q[NS-2:0], in_fire};
      valid_o <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0]    <= particle_tag_i;
    vel_q[0][0] <= vel_w[0];
    vel_q[0][1] <= vel_w[1];
    vel_q[0][2] <= vel_w[2];
    aok_q[0]    <= nrm_stat.nonzero;
    for (int s = 1; s < NS; s++) begin
      tag_q[s] <= tag_q[s-1];
      vel_q[s] <= vel_q[s-1];
      aok_q[s] <= aok_q[s-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Scalar lane: angular speed in rad/s, then times dt; gain times dt.
  // Both products come from the registered time step so they line up.
  // ---------------------------------------------------------------------------
  logic signed [WPW-1:0]  wprod_w, wshift_w;
  logic [GAIN_W+DT_W-1:0] gprod_w;
  logic signed [WW-1:0]   w1_q;
  logic [DT_W-1:0]        dt1_q;
  logic [GDW-1:0]         gdt_q [2:7];
  logic signed [WDW-1:0]  wdprod_w, wdshift_w;
  logic signed [WW-1:0]   wdt_q [2:7];

  always_comb begin
    wprod_w   = WPW'(speed_q) * WPW'($signed(DEG2RAD_Q32));
    wshift_w  = wprod_w >>> 32;
    gprod_w   = (GAIN_W+DT_W)'(gain_q) * (GAIN_W+DT_W)'(dt1_q);
    wdprod_w  = WDW'(w1_q) * WDW'($signed({1'b0, dt1_q}));
    wdshift_w = wdprod_w >>> DT_W;
  end

  always_ff @(posedge clk_i) begin
    w1_q     <= wshift_w[WW-1:0];
    dt1_q    <= time_step_i;
    gdt_q[2] <= gprod_w[GAIN_W+DT_W-1:DT_W];
    wdt_q[2] <= wdshift_w[WW-1:0];
    for (int s = 3; s <= 7; s++) begin
      gdt_q[s] <= gdt_q[s-1];
      wdt_q[s] <= wdt_q[s-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Vector lanes, one stage per register:
  //   1 offset d   2 d*h   3 projection p   4 h*p   5 radial r
  //   6 cross terms   7 tangent c   8 c*wdt, r*gdt   output: sum and saturate
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0]  d1_q [3], d2_q [3], d3_q [3], d4_q [3];
  logic signed [DHW-1:0] dh2_q [3];
  logic signed [PW-1:0]  p3_q;
  logic signed [HPW-1:0] hp4_q [3];
  logic signed [RW-1:0]  r5_q [3], r6_q [3], r7_q [3];
  logic signed [HRW-1:0] ma6_q [3], mb6_q [3];
  logic signed [CW-1:0]  c7_q [3];
  logic signed [CWW-1:0] cw8_q [3];
  logic signed [RGW-1:0] rg8_q [3];
  logic                  rnz6_q, rnz7_q, rnz8_q;
  logic                  rnz5_w;

  logic signed [DSW-1:0] dsum_w, dshift_w;

  always_comb begin
    dsum_w   = DSW'(dh2_q[0]) + DSW'(dh2_q[1]) + DSW'(dh2_q[2]);
    dshift_w = dsum_w >>> FRAC_BITS;
    rnz5_w   = (r5_q[0] != '0) || (r5_q[1] != '0) || (r5_q[2] != '0);
  end

  always_ff @(posedge clk_i) begin
    p3_q   <= dshift_w[PW-1:0];
    rnz6_q <= rnz5_w;
    rnz7_q <= rnz6_q;
    rnz8_q <= rnz7_q;
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    localparam int unsigned K1 = (k + 1) % 3;
    localparam int unsigned K2 = (k + 2) % 3;

    logic signed [HPW-1:0]   hpsh_w;
    logic signed [HRW:0]     cdiff_w, cshift_w;
    logic signed [CWW-1:0]   cwsh_w;
    logic signed [RGW-1:0]   rgsh_w;
    logic signed [SUM_W-1:0] sum_w;
    logic signed [POS_W-1:0] sat_w;
    logic signed [POS_W-1:0] nv_w;

    always_comb begin
      hpsh_w   = hp4_q[k] >>> FRAC_BITS;
      cdiff_w  = (HRW+1)'(ma6_q[k]) - (HRW+1)'(mb6_q[k]);
      cshift_w = cdiff_w >>> FRAC_BITS;
      cwsh_w   = cw8_q[k] >>> FRAC_BITS;
      rgsh_w   = rg8_q[k] >>> FRAC_BITS;
      sum_w    = SUM_W'(vel_q[NS-1][k]) + SUM_W'(cwsh_w) - SUM_W'(rgsh_w);
      if (sum_w > SAT_MAX) begin
        sat_w = SAT_MAX[POS_W-1:0];
      end else if (sum_w < SAT_MIN) begin
        sat_w = SAT_MIN[POS_W-1:0];
      end else begin
        sat_w = sum_w[POS_W-1:0];
      end
      // Hold the incoming velocity when the axis or the radius is zero.
      nv_w = (aok_q[NS-1] && rnz8_q) ? sat_w : vel_q[NS-1][k];
    end

    always_ff @(posedge clk_i) begin
      d1_q[k]  <= DW'(pos_w[k]) - DW'(center_q[k]);
      d2_q[k]  <= d1_q[k];
      dh2_q[k] <= DHW'(d1_q[k]) * DHW'(h_w[k]);
      d3_q[k]  <= d2_q[k];
      d4_q[k]  <= d3_q[k];
      hp4_q[k] <= HPW'(h_w[k]) * HPW'(p3_q);
      r5_q[k]  <= RW'(d4_q[k]) - RW'($signed(hpsh_w[PW-1:0]));
      r6_q[k]  <= r5_q[k];
      ma6_q[k] <= HRW'(h_w[K1]) * HRW'(r5_q[K2]);
      mb6_q[k] <= HRW'(h_w[K2]) * HRW'(r5_q[K1]);
      r7_q[k]  <= r6_q[k];
      c7_q[k]  <= cshift_w[CW-1:0];
      cw8_q[k] <= CWW'(c7_q[k]) * CWW'(wdt_q[7]);
      rg8_q[k] <= RGW'(r7_q[k]) * RGW'($signed({1'b0, gdt_q[7]}));
    end
  end

  always_ff @(posedge clk_i) begin
    out_tag_o   <= tag_q[NS-1];
    applied_o   <= aok_q[NS-1] & rnz8_q;
    new_vel_x_o <= g_lane[0].nv_w;
    new_vel_y_o <= g_lane[1].nv_w;
    new_vel_z_o <= g_lane[2].nv_w;
  end

endmodule
